[src/bft_pkg.sv]
package bft_pkg;

  localparam int TOP_COUNT_DEF  = 10;
  localparam int COUNT_BITS_DEF = 24;
  localparam int NUM_BYTES      = 256;
  localparam int BYTE_W         = 8;
  localparam int DISTINCT_W     = 9;
  localparam int RANK_W         = 4;
  localparam int OCC_W          = 24;
  localparam int QUEUE_DEPTH    = 2;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0]     rank;
    logic [BYTE_W-1:0]     byte_value;
    logic [OCC_W-1:0]      occurrences;
    logic [DISTINCT_W-1:0] distinct_total;
    logic                  last_of_report;
  } out_item_t;

endpackage

[src/byte_frequency_top_k.sv]
// Byte histogram with top-k report. Bytes are counted in a 256-entry memory by
// a read-modify-write: a byte is read in the idle state and its count is written
// in the update state, and no new byte is taken until that write is done. A
// two-entry queue in front absorbs bursts. The byte marked end_of_text starts
// a report: each of up to TOP_COUNT results takes one sweep over the memory,
// then a clear pass runs before the next text is accepted. The same clear pass
// runs after reset. Results leave through an output register.
module byte_frequency_top_k
  import bft_pkg::*;
#(
  parameter int TOP_COUNT  = TOP_COUNT_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic     q_valid, q_ready;
  in_item_t q_data;

  bft_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(in_valid), .push_ready(in_ready), .push_data(in_data),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_data(q_data)
  );

  bft_back #(.TOP_COUNT(TOP_COUNT), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .item_valid(q_valid), .item_ready(q_ready), .item(q_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

[src/bft_ram.sv]
module bft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/bft_queue.sv]
// Short queue between the front (accept) and back (histogram / report).
module bft_queue
  import bft_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  in_item_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output in_item_t pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  in_item_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wptr_r, rptr_r;
  logic [PTR_W:0]       fill_r;
  logic                 push, pop;

  assign push_ready = (fill_r != (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_data   = slot_r[rptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      fill_r <= fill_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  // fill never exceeds the depth
  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= (PTR_W+1)'(QUEUE_DEPTH))
    else $error("queue overfilled");

endmodule

[src/bft_back.sv]
// Histogram update, top-k selection sweep, clear sweep and result register.
module bft_back
  import bft_pkg::*;
#(
  parameter int TOP_COUNT  = TOP_COUNT_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW = $clog2(NUM_BYTES);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam int TK_W = $clog2(TOP_COUNT + 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_UPD   = 6'b000100,
    S_SCAN  = 6'b001000,
    S_EMIT  = 6'b010000,
    S_WAIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // histogram memory: count plus reported flag
  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [COUNT_BITS:0]   wdata, rdata;

  bft_ram #(.WIDTH(COUNT_BITS + 1), .DEPTH(NUM_BYTES)) u_hist (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [AW-1:0]          addr_r;
  logic [AW:0]            scan_r;
  logic                   last_r;
  logic [DISTINCT_W-1:0]  distinct_r;
  logic [TK_W-1:0]        rank_r;
  logic                   found_r;
  logic [AW-1:0]          best_r;
  logic [COUNT_BITS-1:0]  best_cnt_r;
  logic                   ovalid_r;
  out_item_t              odata_r;
  logic                   ofree;

  logic [COUNT_BITS-1:0]  rd_cnt;
  logic                   rd_done;
  logic [AW-1:0]          rd_addr;
  logic [TK_W-1:0]        n_report;

  assign rd_cnt  = rdata[COUNT_BITS-1:0];
  assign rd_done = rdata[COUNT_BITS];
  assign rd_addr = scan_r[AW-1:0] - 1'b1;
  assign ofree   = !ovalid_r || out_ready;
  assign n_report = (distinct_r < DISTINCT_W'(TOP_COUNT)) ?
                    TK_W'(distinct_r) : TK_W'(TOP_COUNT);

  assign item_ready = (state_r == S_IDLE);
  assign out_valid  = ovalid_r;
  assign out_data   = odata_r;

  // read address: incoming byte, or sweep pointer
  always_comb begin
    raddr = item.text_byte;
    if (state_r == S_SCAN) raddr = scan_r[AW-1:0];
  end

  // memory writes: clear sweep, count update, mark reported
  always_comb begin
    we    = 1'b0;
    waddr = addr_r;
    wdata = '0;
    unique case (state_r)
      S_CLEAR: we = 1'b1;
      S_UPD: begin
        we    = 1'b1;
        wdata = {1'b0, (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + 1'b1};
      end
      S_EMIT: begin
        we    = ofree;
        waddr = best_r;
        wdata = {1'b1, best_cnt_r};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (addr_r == AW'(NUM_BYTES - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (item_valid) state_nxt = S_UPD;
      S_UPD:   state_nxt = last_r ? S_SCAN : S_IDLE;
      S_SCAN:  if (scan_r == (AW+1)'(NUM_BYTES)) state_nxt = S_EMIT;
      S_EMIT: begin
        if (ofree) begin
          state_nxt = (rank_r + 1'b1 == n_report) ? S_WAIT : S_SCAN;
        end
      end
      S_WAIT:  state_nxt = S_CLEAR;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      addr_r     <= '0;
      distinct_r <= '0;
      ovalid_r   <= 1'b0;
      rank_r     <= '0;
      scan_r     <= '0;
      found_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // result register: load on emit, drop once taken
      if (state_r == S_EMIT && ofree) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          addr_r     <= addr_r + 1'b1;
          distinct_r <= '0;
          rank_r     <= '0;
        end
        S_IDLE: begin
          if (item_valid) begin
            addr_r <= item.text_byte;
            last_r <= item.end_of_text;
          end
          scan_r  <= '0;
          found_r <= 1'b0;
        end
        S_UPD: begin
          if (rd_cnt == '0) distinct_r <= distinct_r + 1'b1;
        end
        S_SCAN: begin
          scan_r <= scan_r + 1'b1;
          // data for address scan_r-1 arrives this cycle
          if (scan_r != '0 && !rd_done && rd_cnt != '0 &&
              (!found_r || rd_cnt > best_cnt_r)) begin
            found_r    <= 1'b1;
            best_r     <= rd_addr;
            best_cnt_r <= rd_cnt;
          end
        end
        S_EMIT: begin
          if (ofree) begin
            odata_r.rank           <= RANK_W'(rank_r);
            odata_r.byte_value     <= best_r;
            odata_r.occurrences    <= OCC_W'(best_cnt_r);
            odata_r.distinct_total <= distinct_r;
            odata_r.last_of_report <= (rank_r + 1'b1 == n_report);
            rank_r  <= rank_r + 1'b1;
            scan_r  <= '0;
            found_r <= 1'b0;
          end
        end
        S_WAIT: addr_r <= '0;
        default: ;
      endcase
    end
  end

  // a report entry always has a candidate
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> found_r)
    else $error("no candidate at emit");

  // an update follows every accepted byte
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && item_valid) |=> state_r == S_UPD)
    else $error("update missed");

  // rank stays within the report length while emitting
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> rank_r < n_report)
    else $error("rank overrun");

endmodule
